// ===== sv/lps_pkg.sv =====
// ---------------------------------------------------------------------------
// lps_pkg - shared types and constants of the loom pick sequencer
// Action codes, register indexes and the sequencer state type.
// ---------------------------------------------------------------------------
package lps_pkg;

   localparam int unsigned FieldRowWidth  = 10;
   localparam int unsigned MaskWidth      = 32;
   localparam int unsigned RepeatWidth    = 8;
   localparam int unsigned ReqDataWidth   = 80;
   localparam int unsigned RspDataWidth   = 56;

   typedef enum logic [2:0] {
      ACT_WRITE_ROW     = 3'd0,
      ACT_WRITE_TIEUP   = 3'd1,
      ACT_WRITE_BRACKET = 3'd2,
      ACT_REWIND        = 3'd3,
      ACT_PICK_FWD      = 3'd4,
      ACT_PICK_BACK     = 3'd5
   } action_type;

   localparam logic [2:0] RegBitOrder = 3'd0;
   localparam logic [2:0] RegReverse  = 3'd1;
   localparam logic [2:0] RegDirect   = 3'd2;
   localparam logic [2:0] RegShafts   = 3'd3;
   localparam logic [2:0] RegTreadles = 3'd4;
   localparam logic [2:0] RegTieRows  = 3'd5;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ROW_RD,
      ST_ROW_WAIT,
      ST_TIE_RD,
      ST_TIE_ACC,
      ST_ORDER,
      ST_STEP,
      ST_SEARCH,
      ST_FINISH,
      ST_OUT
   } state_type;

endpackage

// ===== sv/lps_tables.sv =====
// ---------------------------------------------------------------------------
// lps_tables - treadling and tie-up memories
// Two synchronous single-port memories with registered read data.
// ---------------------------------------------------------------------------
module lps_tables #(
   parameter int unsigned ROWS         = 1024,
   parameter int unsigned MAX_TREADLES = 32
) (
   input  logic                                  clock,
   input  logic                                  row_we,
   input  logic [$clog2(ROWS)-1:0]               row_addr,
   input  logic [lps_pkg::MaskWidth-1:0]         row_wdata,
   output logic [lps_pkg::MaskWidth-1:0]         row_rdata,
   input  logic                                  tie_we,
   input  logic [$clog2(MAX_TREADLES+1)-1:0]     tie_addr,
   input  logic [lps_pkg::MaskWidth-1:0]         tie_wdata,
   output logic [lps_pkg::MaskWidth-1:0]         tie_rdata
);
   import lps_pkg::*;

   localparam int unsigned TieAw = $clog2(MAX_TREADLES+1);
   localparam int unsigned TieIw = (MAX_TREADLES > 1) ? $clog2(MAX_TREADLES) : 1;

   logic [MaskWidth-1:0] row_mem [ROWS];
   logic [MaskWidth-1:0] tie_mem [MAX_TREADLES];

   // write or read the treadling store
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_addr] <= row_wdata;
      end
      row_rdata <= row_mem[row_addr];
   end

   // write or read the tie-up store; out-of-range reads give zero
   always_ff @(posedge clock) begin
      if (tie_we && (tie_addr < TieAw'(MAX_TREADLES))) begin
         tie_mem[tie_addr[TieIw-1:0]] <= tie_wdata;
      end
      if (tie_addr < TieAw'(MAX_TREADLES)) begin
         tie_rdata <= tie_mem[tie_addr[TieIw-1:0]];
      end else begin
         tie_rdata <= '0;
      end
   end

endmodule

// ===== sv/loom_pick_sequencer.sv =====
// ---------------------------------------------------------------------------
// loom_pick_sequencer - dobby loom pick sequencer
// Holds treadling, tie-up and bracket tables and steps through the pattern.
// ---------------------------------------------------------------------------
// One item at a time. Writes, rewinds and spare action codes pass through
// ST_ROW_RD, ST_FINISH and ST_OUT before their result is raised. A pick reads
// its treadling row and goes to ST_ORDER in direct mode; through the tie-up
// it first does a memory read and an accumulate per treadle (count clamped to
// MAX_TREADLES). It then steps, with a bracket search at the end of a bracket. The
// next item can be accepted in the same cycle that the result is raised. The
// result waits in an output register while the next item is processed; a
// finished item waits only while the previous result has not been taken.
// Treadling and tie-up entries are undefined until written.
module loom_pick_sequencer #(
   parameter int unsigned BRACKETS     = 8,
   parameter int unsigned ROWS         = 1024,
   parameter int unsigned MAX_TREADLES = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [2:0]                        csr_index,
   input  logic [7:0]                        csr_data,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // action[2:0], index[12:3], row_bits[44:13], bracket_first[54:45],
   // bracket_last[64:55], bracket_repeats[72:65] -> see below
   // lowest up: action 3, index 10, row_bits 32, bracket_first 10,
   // bracket_last 10, bracket_repeats 8, zero fill to 80
   input  logic [lps_pkg::ReqDataWidth-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // lowest up: shaft_mask 32, cur_row 10, cur_bracket 4, cur_repeat 8,
   // at_start 1, no_active 1, zero fill to 56
   output logic [lps_pkg::RspDataWidth-1:0]  rsp_tdata
);
   import lps_pkg::*;

   localparam int unsigned BiW  = $clog2(BRACKETS+1);
   localparam int unsigned BaW  = (BRACKETS > 1) ? $clog2(BRACKETS) : 1;
   localparam int unsigned RaW  = $clog2(ROWS);
   localparam int unsigned TaW  = $clog2(MAX_TREADLES+1);

   // configuration
   logic [1:0] order_ff;
   logic       rev_ff, direct_ff;
   logic [5:0] shafts_ff, treadles_ff, tierows_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff    <= 2'd1;
         rev_ff      <= 1'b0;
         direct_ff   <= 1'b0;
         shafts_ff   <= 6'd24;
         treadles_ff <= 6'd24;
         tierows_ff  <= 6'd24;
      end else if (csr_valid) begin
         case (csr_index)
            RegBitOrder: order_ff    <= csr_data[1:0];
            RegReverse:  rev_ff      <= csr_data[0];
            RegDirect:   direct_ff   <= csr_data[0];
            RegShafts:   shafts_ff   <= csr_data[5:0];
            RegTreadles: treadles_ff <= csr_data[5:0];
            RegTieRows:  tierows_ff  <= csr_data[5:0];
            default: ;
         endcase
      end
   end

   // request fields
   logic [2:0]  r_act;
   logic [9:0]  r_idx, r_first, r_last;
   logic [31:0] r_bits;
   logic [7:0]  r_reps;

   // state registers
   state_type st_ff, st_in;
   logic [2:0]  act_ff;
   logic [9:0]  idx_ff, bf_ff, bl_ff;
   logic [31:0] bits_ff;
   logic [7:0]  brep_ff;
   logic [15:0] row_ff;           // position, wide enough for ROWS
   logic [BiW-1:0] bidx_ff;
   logic [7:0]  rep_ff;
   logic [31:0] trow_ff, acc_ff, mask_ff;
   logic [5:0]  cnt_ff;
   logic [BiW-1:0] scan_ff;
   logic        fail_ff;
   logic [RspDataWidth-1:0] out_ff;
   logic        out_valid_ff;
   logic        out_free;

   // bracket table in flip-flops with reset
   logic [9:0] brf_ff [BRACKETS];
   logic [9:0] brl_ff [BRACKETS];
   logic [7:0] brr_ff [BRACKETS];

   assign r_act   = req_tdata[2:0];
   assign r_idx   = req_tdata[12:3];
   assign r_bits  = req_tdata[44:13];
   assign r_first = req_tdata[54:45];
   assign r_last  = req_tdata[64:55];
   assign r_reps  = req_tdata[72:65];

   assign req_tready = (st_ff == ST_IDLE);

   // output register can take a new result
   assign out_free = !out_valid_ff || rsp_tready;

   // memories
   logic        row_we, tie_we;
   logic [RaW-1:0] row_addr;
   logic [TaW-1:0] tie_addr;
   logic [31:0] row_rdata, tie_rdata;

   lps_tables #(.ROWS(ROWS), .MAX_TREADLES(MAX_TREADLES)) u_tables (
      .clock(clock), .row_we(row_we), .row_addr(row_addr), .row_wdata(bits_ff),
      .row_rdata(row_rdata), .tie_we(tie_we), .tie_addr(tie_addr),
      .tie_wdata(bits_ff), .tie_rdata(tie_rdata)
   );

   assign row_we   = (st_ff == ST_ROW_RD) && (act_ff == ACT_WRITE_ROW)
                     && (32'(idx_ff) < 32'(ROWS));
   assign row_addr = (st_ff == ST_ROW_RD && act_ff == ACT_WRITE_ROW)
                     ? RaW'(idx_ff) : RaW'(row_ff);
   assign tie_we   = (st_ff == ST_ROW_RD) && (act_ff == ACT_WRITE_TIEUP)
                     && (32'(idx_ff) < 32'(MAX_TREADLES));
   assign tie_addr = (st_ff == ST_ROW_RD) ? TaW'(idx_ff) : TaW'(cnt_ff);

   // clamped counts
   logic [5:0] tc, sc, trc, mi, mj;
   always_comb begin
      tc  = (treadles_ff > 6'(MAX_TREADLES)) ? 6'(MAX_TREADLES) : treadles_ff;
      sc  = (shafts_ff > 6'(MAX_TREADLES)) ? 6'(MAX_TREADLES) : shafts_ff;
      trc = (tierows_ff > 6'(MAX_TREADLES)) ? 6'(MAX_TREADLES) : tierows_ff;
      if (order_ff == 2'd0) mi = (tc < 6'd24) ? tc : 6'd24;
      else                  mi = (tc < sc) ? tc : sc;
      mj = (mi < trc) ? mi : trc;
   end

   // reorder shaft bits into mask positions
   logic [31:0] ordered;
   always_comb begin
      logic [31:0] src;
      logic [5:0]  lim;
      logic [5:0]  pos;
      src = direct_ff ? trow_ff : acc_ff;
      lim = direct_ff ? mi : mj;
      ordered = '0;
      for (int k = 0; k < 32; k++) begin
         pos = 6'd0;
         if (order_ff == 2'd0)      pos = rev_ff ? 6'(k) : 6'(23 - k);
         else if (order_ff == 2'd2) pos = rev_ff ? 6'(mi - 6'd1 - 6'(k)) : 6'(k);
         else                       pos = rev_ff ? 6'(k) : 6'(mi - 6'd1 - 6'(k));
         if ((6'(k) < lim) && src[k]) ordered[pos[4:0]] = 1'b1;
      end
   end

   // first active bracket
   logic [BiW-1:0] fa;
   always_comb begin
      fa = BiW'(BRACKETS);
      for (int b = BRACKETS - 1; b >= 0; b--) begin
         if (brr_ff[b] != 8'd0) fa = BiW'(b);
      end
   end

   logic [BiW-1:0] cb;
   assign cb = (bidx_ff < BiW'(BRACKETS)) ? bidx_ff : '0;

   // next search candidate
   logic [BiW-1:0] cand;
   always_comb begin
      if (act_ff == ACT_PICK_FWD)
         cand = (scan_ff == BiW'(BRACKETS - 1)) ? '0 : BiW'(scan_ff + 1'b1);
      else
         cand = (scan_ff == '0) ? BiW'(BRACKETS - 1) : BiW'(scan_ff - 1'b1);
   end

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:     if (req_tvalid && req_tready) st_in = ST_ROW_RD;
         ST_ROW_RD: begin
            if (act_ff == ACT_PICK_FWD || act_ff == ACT_PICK_BACK) st_in = ST_ROW_WAIT;
            else st_in = ST_FINISH;
         end
         ST_ROW_WAIT: st_in = direct_ff ? ST_ORDER : ST_TIE_RD;
         ST_TIE_RD:   st_in = (cnt_ff < tc) ? ST_TIE_ACC : ST_ORDER;
         ST_TIE_ACC:  st_in = ST_TIE_RD;
         ST_ORDER:    st_in = ST_STEP;
         ST_STEP:     st_in = ST_SEARCH;
         ST_SEARCH:   if (cnt_ff[4:0] == 5'd0 || fail_ff) st_in = ST_FINISH;
         ST_FINISH:   if (out_free) st_in = ST_OUT;
         ST_OUT:      st_in = ST_IDLE;
         default:     st_in = ST_IDLE;
      endcase
   end

   // datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         row_ff       <= '0;
         bidx_ff      <= '0;
         rep_ff       <= 8'd1;
         out_valid_ff <= 1'b0;
         for (int b = 0; b < BRACKETS; b++) begin
            brf_ff[b] <= '0;
            brl_ff[b] <= '0;
            brr_ff[b] <= '0;
         end
      end else begin
         st_ff <= st_in;
         if (rsp_tvalid && rsp_tready) out_valid_ff <= 1'b0;
         case (st_ff)
            ST_IDLE: begin
               act_ff  <= r_act;  idx_ff <= r_idx; bits_ff <= r_bits;
               bf_ff   <= r_first; bl_ff <= r_last; brep_ff <= r_reps;
               mask_ff <= '0; fail_ff <= 1'b0; acc_ff <= '0; cnt_ff <= '0;
            end
            ST_ROW_RD: begin
               if (act_ff == ACT_WRITE_BRACKET && 32'(idx_ff) < 32'(BRACKETS)) begin
                  brf_ff[idx_ff[BaW-1:0]] <= bf_ff;
                  brl_ff[idx_ff[BaW-1:0]] <= bl_ff;
                  brr_ff[idx_ff[BaW-1:0]] <= brep_ff;
               end
               if (act_ff == ACT_REWIND) begin
                  rep_ff <= 8'd1;
                  if (fa < BiW'(BRACKETS)) begin
                     bidx_ff <= fa; row_ff <= 16'(brf_ff[fa[BaW-1:0]]);
                  end else begin
                     bidx_ff <= '0; row_ff <= '0; fail_ff <= 1'b1;
                  end
               end
            end
            ST_ROW_WAIT: trow_ff <= (32'(row_ff) < 32'(ROWS)) ? row_rdata : '0;
            ST_TIE_ACC: begin
               if (trow_ff[cnt_ff[4:0]]) acc_ff <= acc_ff | tie_rdata;
               cnt_ff <= cnt_ff + 6'd1;
            end
            ST_ORDER: mask_ff <= ordered;
            ST_STEP: begin
               cnt_ff  <= 6'd0;
               scan_ff <= cb;
               if (act_ff == ACT_PICK_FWD) begin
                  if (17'(row_ff) + 17'd1 <= 17'(brl_ff[cb[BaW-1:0]]))
                     row_ff <= row_ff + 16'd1;
                  else if (rep_ff < brr_ff[cb[BaW-1:0]]) begin
                     rep_ff <= rep_ff + 8'd1; row_ff <= 16'(brf_ff[cb[BaW-1:0]]);
                  end else cnt_ff <= 6'(BRACKETS);
               end else begin
                  if (row_ff > 16'(brf_ff[cb[BaW-1:0]])) row_ff <= row_ff - 16'd1;
                  else if (rep_ff > 8'd1) begin
                     rep_ff <= rep_ff - 8'd1; row_ff <= 16'(brl_ff[cb[BaW-1:0]]);
                  end else cnt_ff <= 6'(BRACKETS);
               end
            end
            ST_SEARCH: begin
               if (cnt_ff != 6'd0) begin
                  scan_ff <= cand;
                  cnt_ff  <= cnt_ff - 6'd1;
                  if (brr_ff[cand[BaW-1:0]] != 8'd0) begin
                     cnt_ff  <= 6'd0;
                     bidx_ff <= cand;
                     if (act_ff == ACT_PICK_FWD) begin
                        rep_ff <= 8'd1; row_ff <= 16'(brf_ff[cand[BaW-1:0]]);
                     end else begin
                        rep_ff <= brr_ff[cand[BaW-1:0]];
                        row_ff <= 16'(brl_ff[cand[BaW-1:0]]);
                     end
                  end else if (cnt_ff == 6'd1) fail_ff <= 1'b1;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  out_ff <= {
                     fail_ff,
                     (fa < BiW'(BRACKETS) && bidx_ff == fa
                        && row_ff == 16'(brf_ff[fa[BaW-1:0]]) && rep_ff == 8'd1),
                     rep_ff,
                     4'((fa < BiW'(BRACKETS)) ? bidx_ff : BiW'(BRACKETS)),
                     row_ff[9:0],
                     mask_ff };
               end
            end
            ST_OUT: out_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

// ===== sv/lps_checker.sv =====
// ---------------------------------------------------------------------------
// lps_checker - port-level checks of the loom pick sequencer
// Watches the handshakes and result fields over time.
// ---------------------------------------------------------------------------
module lps_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   // one item in flight: ready drops right after an accept
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("accept while busy");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed under stall");

   // an accepted item does not raise a result in the next cycle
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !rsp_tvalid |=> !rsp_tvalid)
      else $error("result too early");

   // no_active implies at_start low
   a_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[55] |-> !rsp_tdata[54]) else $error("flag clash");
endmodule

bind loom_pick_sequencer lps_checker u_lps_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// ===== dv/loom_pick_sequencer_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// loom_pick_sequencer_test - self-checking bench for the pick sequencer
// Fills the tie-up and treadling tables, sets up repeat brackets and walks
// the pattern forward and back under several register settings, comparing
// every result item field by field with an in-bench model of the sequencer.
// ---------------------------------------------------------------------------
module loom_pick_sequencer_test;
   import lps_pkg::*;

   localparam int unsigned NumBrackets = 8;
   localparam int unsigned NumRows     = 1024;
   localparam int unsigned NumTreadles = 32;
   localparam int unsigned CycleLimit  = 2000000;
   localparam logic [2:0]  ActSpareLow  = 3'd6;
   localparam logic [2:0]  ActSpareHigh = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [9:0]  index;
      logic [31:0] row_bits;
      logic [9:0]  first;
      logic [9:0]  last;
      logic [7:0]  repeats;
   } pick_item;

   typedef struct packed {
      logic [31:0] shaft_mask;
      logic [9:0]  row;
      logic [3:0]  bracket;
      logic [7:0]  repeat_no;
      logic        at_start;
      logic        no_active;
   } pick_result;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;

   // sequencer copy held by the bench
   logic [31:0] treadling [NumRows];
   bit          row_written [NumRows];
   logic [31:0] tieup [NumTreadles];
   int unsigned br_first [NumBrackets];
   int unsigned br_last [NumBrackets];
   int unsigned br_reps [NumBrackets];
   int unsigned row_pos;
   int unsigned bracket_no;
   int unsigned repeat_no;
   int unsigned order_mode;
   int unsigned reverse_bits;
   int unsigned direct_mode;
   int unsigned shafts;
   int unsigned treadles;
   int unsigned tie_rows;

   pick_result  pending_results[$];
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned mismatches;
   int unsigned results_seen;
   int unsigned picks_sent;
   int unsigned cycles;

   loom_pick_sequencer dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      // lowest up: action, index, row_bits, bracket_first, bracket_last,
      // bracket_repeats, zero fill
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      // lowest up: shaft_mask, cur_row, cur_bracket, cur_repeat, at_start,
      // no_active, zero fill
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic int unsigned clamp_count(int unsigned v);
      return v > NumTreadles ? NumTreadles : v;
   endfunction

   function automatic int unsigned lower(int unsigned a, int unsigned b);
      return a < b ? a : b;
   endfunction

   function automatic int unsigned lift_bit(int unsigned k, int unsigned m);
      if (order_mode == 0) return reverse_bits ? k : 23 - k;
      if (order_mode == 2) return reverse_bits ? m - 1 - k : k;
      return reverse_bits ? k : m - 1 - k;
   endfunction

   function automatic logic [31:0] shaft_mask_of_row();
      int unsigned tc;
      int unsigned mi;
      int unsigned mj;
      logic [31:0] rowv;
      logic [31:0] mask;
      tc = clamp_count(treadles);
      mi = (order_mode == 0) ? lower(tc, 24) : lower(tc, clamp_count(shafts));
      mj = lower(mi, clamp_count(tie_rows));
      rowv = treadling[row_pos];
      mask = '0;
      if (direct_mode != 0) begin
         for (int unsigned i = 0; i < mi; i++)
            if (rowv[i]) mask[lift_bit(i, mi)] = 1'b1;
      end else begin
         for (int unsigned i = 0; i < tc; i++) begin
            if (!rowv[i]) continue;
            for (int unsigned k = 0; k < mj; k++)
               if (tieup[i][k]) mask[lift_bit(k, mi)] = 1'b1;
         end
      end
      return mask;
   endfunction

   function automatic int unsigned first_active();
      for (int unsigned b = 0; b < NumBrackets; b++)
         if (br_reps[b] != 0) return b;
      return NumBrackets;
   endfunction

   // step one row forward; return 0 when no bracket is active
   function automatic bit step_forward();
      int unsigned c;
      if (row_pos + 1 <= br_last[bracket_no]) begin
         row_pos++;
         return 1;
      end
      if (repeat_no < br_reps[bracket_no]) begin
         repeat_no++;
         row_pos = br_first[bracket_no];
         return 1;
      end
      for (int unsigned n = 1; n <= NumBrackets; n++) begin
         c = (bracket_no + n) % NumBrackets;
         if (br_reps[c] != 0) begin
            bracket_no = c;
            repeat_no = 1;
            row_pos = br_first[c];
            return 1;
         end
      end
      return 0;
   endfunction

   function automatic bit step_back();
      int unsigned c;
      if (row_pos > br_first[bracket_no]) begin
         row_pos--;
         return 1;
      end
      if (repeat_no > 1) begin
         repeat_no--;
         row_pos = br_last[bracket_no];
         return 1;
      end
      for (int unsigned n = 1; n <= NumBrackets; n++) begin
         c = (bracket_no + 2 * NumBrackets - n) % NumBrackets;
         if (br_reps[c] != 0) begin
            bracket_no = c;
            repeat_no = br_reps[c];
            row_pos = br_last[c];
            return 1;
         end
      end
      return 0;
   endfunction

   // apply one item to the bench copy and return the result it gives
   function automatic pick_result advance_sequencer(pick_item it);
      pick_result r;
      int unsigned fa;
      bit failed;
      r = '0;
      failed = 0;
      case (it.action)
         ACT_WRITE_ROW: begin
            treadling[it.index] = it.row_bits;
            row_written[it.index] = 1;
         end
         ACT_WRITE_TIEUP:
            if (it.index < NumTreadles) tieup[it.index] = it.row_bits;
         ACT_WRITE_BRACKET:
            if (it.index < NumBrackets) begin
               br_first[it.index] = it.first;
               br_last[it.index] = it.last;
               br_reps[it.index] = it.repeats;
            end
         ACT_REWIND: begin
            fa = first_active();
            repeat_no = 1;
            if (fa < NumBrackets) begin
               bracket_no = fa;
               row_pos = br_first[fa];
            end else begin
               bracket_no = 0;
               row_pos = 0;
               failed = 1;
            end
         end
         ACT_PICK_FWD: begin
            r.shaft_mask = shaft_mask_of_row();
            failed = !step_forward();
         end
         ACT_PICK_BACK: begin
            r.shaft_mask = shaft_mask_of_row();
            failed = !step_back();
         end
         default: ;
      endcase
      fa = first_active();
      r.row = row_pos[9:0];
      r.bracket = (fa < NumBrackets) ? bracket_no[3:0] : 4'(NumBrackets);
      r.repeat_no = repeat_no[7:0];
      r.at_start = (fa < NumBrackets && bracket_no == fa && row_pos == br_first[fa]
                    && repeat_no == 1);
      r.no_active = failed;
      return r;
   endfunction

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h, expected %0h (result %0d)", what, got, want,
               results_seen);
      mismatches++;
   endtask

   // collect and check result items; stall the receiver at random
   always @(posedge clock) begin
      pick_result got;
      pick_result want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[55:0];
            got = {rsp_tdata[31:0], rsp_tdata[41:32], rsp_tdata[45:42],
                   rsp_tdata[53:46], rsp_tdata[54], rsp_tdata[55]};
            results_seen++;
            if (pending_results.size() == 0) begin
               report("unexpected item", got.shaft_mask, 0);
            end else begin
               want = pending_results.pop_front();
               if (got.shaft_mask !== want.shaft_mask)
                  report("shaft_mask", got.shaft_mask, want.shaft_mask);
               if (got.row !== want.row) report("cur_row", got.row, want.row);
               if (got.bracket !== want.bracket)
                  report("cur_bracket", got.bracket, want.bracket);
               if (got.repeat_no !== want.repeat_no)
                  report("cur_repeat", got.repeat_no, want.repeat_no);
               if (got.at_start !== want.at_start)
                  report("at_start", got.at_start, want.at_start);
               if (got.no_active !== want.no_active)
                  report("no_active", got.no_active, want.no_active);
            end
         end
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // offer one item, wait for it to be taken, then record its result
   task automatic send_item(pick_item it);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, it.repeats, it.last, it.first, it.row_bits, it.index,
                    it.action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(advance_sequencer(it));
      if (it.action == ACT_PICK_FWD || it.action == ACT_PICK_BACK) picks_sent++;
   endtask

   task automatic send_plain(logic [2:0] action, int unsigned index, logic [31:0] bits);
      pick_item it;
      it = '0;
      it.action = action;
      it.index = index[9:0];
      it.row_bits = bits;
      send_item(it);
   endtask

   task automatic send_bracket(int unsigned index, int unsigned first, int unsigned last,
                               int unsigned reps);
      pick_item it;
      it = '0;
      it.action = ACT_WRITE_BRACKET;
      it.index = index[9:0];
      it.first = first[9:0];
      it.last = last[9:0];
      it.repeats = reps[7:0];
      it.row_bits = $urandom;
      send_item(it);
   endtask

   // pick, first filling the current row if it was never written
   task automatic send_pick(logic [2:0] action);
      if (!row_written[row_pos]) send_plain(ACT_WRITE_ROW, row_pos, $urandom);
      send_plain(action, $urandom_range(1023), $urandom);
   endtask

   // let every result drain before touching registers
   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // hold one register write until taken; the caller drops valid after the last
   task automatic write_reg(logic [2:0] index, int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value[7:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         RegBitOrder: order_mode = value & 3;
         RegReverse:  reverse_bits = value & 1;
         RegDirect:   direct_mode = value & 1;
         RegShafts:   shafts = value & 63;
         RegTreadles: treadles = value & 63;
         RegTieRows:  tie_rows = value & 63;
         default: ;
      endcase
   endtask

   task automatic set_regs(int unsigned ord, int unsigned rev, int unsigned dir,
                           int unsigned sc, int unsigned tc, int unsigned tr);
      drain();
      write_reg(RegBitOrder, ord);
      write_reg(RegReverse, rev);
      write_reg(RegDirect, dir);
      write_reg(RegShafts, sc);
      write_reg(RegTreadles, tc);
      write_reg(RegTieRows, tr);
      csr_valid <= 1'b0;
   endtask

   // directed: empty table, extremes, out-of-range writes, spare codes
   task automatic test_directed();
      for (int unsigned t = 0; t < NumTreadles; t++)
         send_plain(ACT_WRITE_TIEUP, t, (t == 0) ? 32'hFFFF_FFFF : $urandom);
      send_plain(ACT_REWIND, 0, '0);
      send_plain(ACT_WRITE_ROW, 0, 32'hFFFF_FFFF);
      send_pick(ACT_PICK_FWD);
      send_pick(ACT_PICK_BACK);
      send_plain(ACT_WRITE_TIEUP, 32, 32'hDEAD_BEEF);
      send_plain(ACT_WRITE_TIEUP, 1023, 32'h1234_5678);
      send_bracket(8, 5, 6, 3);
      send_bracket(1023, 5, 6, 3);
      send_plain(ActSpareLow, 0, 32'hFFFF_FFFF);
      send_plain(ActSpareHigh, 1023, 32'hFFFF_FFFF);
      send_plain(ACT_WRITE_ROW, 1023, 32'h0000_0001);
      send_bracket(0, 0, 1, 2);
      send_bracket(7, 1022, 1023, 1);
      send_plain(ACT_REWIND, 0, '0);
      repeat (8) send_pick(ACT_PICK_FWD);
      repeat (8) send_pick(ACT_PICK_BACK);
      send_bracket(2, 1023, 1023, 255);
      send_pick(ACT_PICK_BACK);
      send_bracket(0, 0, 0, 0);
      send_bracket(7, 0, 0, 0);
      send_bracket(2, 0, 0, 0);
      send_pick(ACT_PICK_FWD);
      send_pick(ACT_PICK_BACK);
   endtask

   // random: mostly picks over short random brackets, some writes and noise
   task automatic test_random(int unsigned count);
      int unsigned sel;
      int unsigned first;
      for (int unsigned n = 0; n < count; n++) begin
         sel = $urandom_range(99);
         first = $urandom_range(1023);
         if (sel < 8)
            send_plain(ACT_WRITE_ROW, $urandom_range(1023), $urandom);
         else if (sel < 12)
            send_plain(ACT_WRITE_TIEUP, ($urandom_range(9) == 0) ?
                       $urandom_range(1023) : $urandom_range(31), $urandom);
         else if (sel < 20)
            send_bracket(($urandom_range(9) == 0) ? $urandom_range(1023) :
                         $urandom_range(NumBrackets - 1), first,
                         ($urandom_range(9) == 0) ? $urandom_range(1023) :
                         lower(first + $urandom_range(5), 1023),
                         ($urandom_range(7) == 0) ? $urandom_range(255) :
                         $urandom_range(3));
         else if (sel < 23)
            send_plain(ACT_REWIND, $urandom_range(1023), $urandom);
         else if (sel < 63)
            send_pick(ACT_PICK_FWD);
         else if (sel < 97)
            send_pick(ACT_PICK_BACK);
         else
            send_plain($urandom_range(1) ? ActSpareLow : ActSpareHigh,
                       $urandom_range(1023), $urandom);
      end
   endtask

   task automatic test_settings(int unsigned phase, int unsigned count);
      case (phase)
         0: set_regs(0, 0, 0, 32, 32, 32);
         1: set_regs(2, 1, 1, 1, 32, 1);
         2: set_regs(1, 1, 0, 1, 1, 32);
         3: set_regs(0, 1, 1, 32, 32, 1);
         4: set_regs(2, 0, 0, 24, 32, 32);
         default: set_regs($urandom_range(2), $urandom_range(1), $urandom_range(1),
                           $urandom_range(1, 32), $urandom_range(1, 32),
                           $urandom_range(1, 32));
      endcase
      test_random(count);
   endtask

   initial begin
      order_mode = 1; reverse_bits = 0; direct_mode = 0;
      shafts = 24; treadles = 24; tie_rows = 24;
      row_pos = 0; bracket_no = 0; repeat_no = 1;
      for (int unsigned b = 0; b < NumBrackets; b++) begin
         br_first[b] = 0; br_last[b] = 0; br_reps[b] = 0;
      end
      for (int unsigned r = 0; r < NumRows; r++) begin
         treadling[r] = '0; row_written[r] = 0;
      end
      sender_idle_pct = 22;
      receiver_idle_pct = 63;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      for (int unsigned p = 0; p < 9; p++) begin
         if (p == 3) begin
            sender_idle_pct = 63; receiver_idle_pct = 22;
         end else if (p == 6) begin
            sender_idle_pct = 0; receiver_idle_pct = 0;
         end
         test_settings(p, 170);
      end
      drain();
      repeat (50) @(posedge clock);

      $display("covered %0d picks and %0d result items over nine register settings",
               picks_sent, results_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial cycles = 0;

endmodule
